// File: hdl/e2u_pkg.sv
// ----------------------------------------------------------------------------
// e2u_pkg
// Shared types, constants and calendar functions for the epoch to UTC
// converter.
// ----------------------------------------------------------------------------
package e2u_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned BASE_YEAR     = 1970;

    localparam logic [11:0] BASE_YEAR_W   = 12'(BASE_YEAR);
    localparam logic [1:0]  BASE_MOD4     = 2'(BASE_YEAR % 4);
    localparam logic [6:0]  BASE_MOD100   = 7'(BASE_YEAR % 100);
    localparam logic [8:0]  BASE_MOD400   = 9'(BASE_YEAR % 400);

    // Each reciprocal is floor(2**shift / divisor) with 2**shift above the
    // largest dividend, so the estimated quotient is at most one too low.
    localparam logic [15:0] DAY_RECIP  = 16'(2.0 ** 32 / SECS_PER_DAY - 0.5);
    localparam logic [15:0] HOUR_RECIP = 16'd36;
    localparam logic [15:0] MIN_RECIP  = 16'd68;
    localparam int unsigned DAY_SHIFT  = 32;
    localparam int unsigned HOUR_SHIFT = 17;
    localparam int unsigned MIN_SHIFT  = 12;

    localparam int unsigned REM_W   = 18;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned STEP_W  = 2;

    localparam logic [1:0] DIV_DAY  = 2'd0;
    localparam logic [1:0] DIV_HOUR = 2'd1;
    localparam logic [1:0] DIV_MIN  = 2'd2;

    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] FEB        = 4'd1;

    typedef struct packed {
        logic       load;
        logic       div_est;
        logic       div_rem;
        logic       div_fix;
        logic [1:0] div_sel;
        logic       year_step;
        logic       month_step;
        logic       publish;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    function automatic logic is_leap(input logic [1:0] mod4, input logic [6:0] mod100,
                                     input logic [8:0] mod400);
        is_leap = (mod400 == 9'd0) || ((mod100 != 7'd0) && (mod4 == 2'd0));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] mi, input logic leap);
        logic [4:0] len;
        unique case (mi)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            FEB:                                       len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd31;
        endcase
        month_length = len;
    endfunction

endpackage

// File: hdl/epoch_to_utc_converter.sv
// ----------------------------------------------------------------------------
// epoch_to_utc_converter
// Converts unsigned Unix seconds to the Gregorian UTC date and time of day.
// ----------------------------------------------------------------------------
// An accepted word passes through the load, the estimate, remainder and fix
// steps of the day, hour and minute divisions, one year step per year past
// 1970, one month step per month passed, and the publish, which waits while the
// output register still holds an unaccepted result. One word is converted at a
// time; a new word is taken while the previous result waits in the output register.
// Reset (synchronous, active low) clears the controller and drops m_valid.
module epoch_to_utc_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);

    e2u_pkg::cmd_t    cmd;
    e2u_pkg::status_t status;

    e2u_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    e2u_dpath u_dpath (
        .aclk            (aclk),
        .s_epoch_seconds (s_epoch_seconds),
        .cmd             (cmd),
        .status          (status),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second)
    );

endmodule

// File: hdl/e2u_dpath.sv
// ----------------------------------------------------------------------------
// e2u_dpath
// Datapath: shared reciprocal divider for the day, hour and minute splits,
// year and month subtraction registers and the output word register.
// ----------------------------------------------------------------------------
module e2u_dpath (
    input  logic                           aclk,
    input  logic [31:0]                    s_epoch_seconds,
    input  e2u_pkg::cmd_t                  cmd,
    output e2u_pkg::status_t               status,
    output logic [11:0]                    m_year,
    output logic [3:0]                     m_month,
    output logic [4:0]                     m_day,
    output logic [4:0]                     m_hour,
    output logic [5:0]                     m_minute,
    output logic [5:0]                     m_second
);

    logic [31:0]                num_reg, num_next;
    logic [e2u_pkg::DAYS_W-1:0] qest_reg, qest_next;
    logic [e2u_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [e2u_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [11:0]                year_reg, year_next;
    logic [1:0]                 mod4_reg, mod4_next;
    logic [6:0]                 mod100_reg, mod100_next;
    logic [8:0]                 mod400_reg, mod400_next;
    logic [3:0]                 mi_reg, mi_next;
    logic [4:0]                 hour_reg, hour_next;
    logic [5:0]                 minute_reg, minute_next;
    logic [5:0]                 second_reg, second_next;

    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_minute_reg;
    logic [5:0]  out_second_reg;

    logic [15:0]                recip;
    logic [16:0]                divisor;
    logic [47:0]                prod;
    logic [e2u_pkg::DAYS_W-1:0] qest_calc;
    logic [32:0]                back;
    logic [32:0]                diff;
    logic                       ge;
    logic [e2u_pkg::DAYS_W-1:0] q_fix;
    logic [16:0]                r_fix;
    logic                       leap;
    logic [8:0]                 ylen;
    logic [4:0]                 mlen;

    always_comb begin
        unique case (cmd.div_sel)
            e2u_pkg::DIV_DAY: begin
                recip   = e2u_pkg::DAY_RECIP;
                divisor = 17'(e2u_pkg::SECS_PER_DAY);
            end
            e2u_pkg::DIV_HOUR: begin
                recip   = e2u_pkg::HOUR_RECIP;
                divisor = 17'(e2u_pkg::SECS_PER_HOUR);
            end
            default: begin
                recip   = e2u_pkg::MIN_RECIP;
                divisor = 17'(e2u_pkg::SECS_PER_MIN);
            end
        endcase
    end

    assign prod = 48'(num_reg) * 48'(recip);

    always_comb begin
        unique case (cmd.div_sel)
            e2u_pkg::DIV_DAY:  qest_calc = e2u_pkg::DAYS_W'(prod >> e2u_pkg::DAY_SHIFT);
            e2u_pkg::DIV_HOUR: qest_calc = e2u_pkg::DAYS_W'(prod >> e2u_pkg::HOUR_SHIFT);
            default:           qest_calc = e2u_pkg::DAYS_W'(prod >> e2u_pkg::MIN_SHIFT);
        endcase
    end

    assign back  = 33'(qest_reg) * 33'(divisor);
    assign diff  = {1'b0, num_reg} - back;
    assign ge    = (rem_reg >= {1'b0, divisor});
    assign q_fix = qest_reg + e2u_pkg::DAYS_W'(ge);
    assign r_fix = ge ? 17'(rem_reg - {1'b0, divisor}) : rem_reg[16:0];

    assign leap = e2u_pkg::is_leap(mod4_reg, mod100_reg, mod400_reg);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = e2u_pkg::month_length(mi_reg, leap);

    assign status.year_done  = (days_reg < e2u_pkg::DAYS_W'(ylen));
    assign status.month_done = (mi_reg == e2u_pkg::LAST_MONTH) ||
                               (days_reg < e2u_pkg::DAYS_W'(mlen));

    always_comb begin
        num_next    = num_reg;
        qest_next   = qest_reg;
        rem_next    = rem_reg;
        days_next   = days_reg;
        year_next   = year_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        mi_next     = mi_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;

        if (cmd.load) begin
            num_next = s_epoch_seconds;
        end else if (cmd.div_est) begin
            qest_next = qest_calc;
        end else if (cmd.div_rem) begin
            rem_next = diff[e2u_pkg::REM_W-1:0];
        end else if (cmd.div_fix) begin
            unique case (cmd.div_sel)
                e2u_pkg::DIV_DAY: begin
                    days_next = q_fix;
                    num_next  = {15'd0, r_fix};
                end
                e2u_pkg::DIV_HOUR: begin
                    hour_next = q_fix[4:0];
                    num_next  = {15'd0, r_fix};
                end
                default: begin
                    minute_next = q_fix[5:0];
                    second_next = r_fix[5:0];
                    year_next   = e2u_pkg::BASE_YEAR_W;
                    mod4_next   = e2u_pkg::BASE_MOD4;
                    mod100_next = e2u_pkg::BASE_MOD100;
                    mod400_next = e2u_pkg::BASE_MOD400;
                    mi_next     = 4'd0;
                end
            endcase
        end else if (cmd.year_step) begin
            days_next   = days_reg - e2u_pkg::DAYS_W'(ylen);
            year_next   = year_reg + 12'd1;
            mod4_next   = mod4_reg + 2'd1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end else if (cmd.month_step) begin
            days_next = days_reg - e2u_pkg::DAYS_W'(mlen);
            mi_next   = mi_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        qest_reg   <= qest_next;
        rem_reg    <= rem_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        mod4_reg   <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        mi_reg     <= mi_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        if (cmd.publish) begin
            out_year_reg   <= year_reg;
            out_month_reg  <= mi_reg + 4'd1;
            out_day_reg    <= days_reg[4:0] + 5'd1;
            out_hour_reg   <= hour_reg;
            out_minute_reg <= minute_reg;
            out_second_reg <= second_reg;
        end
    end

    assign m_year   = out_year_reg;
    assign m_month  = out_month_reg;
    assign m_day    = out_day_reg;
    assign m_hour   = out_hour_reg;
    assign m_minute = out_minute_reg;
    assign m_second = out_second_reg;

endmodule

// File: hdl/e2u_ctrl.sv
// ----------------------------------------------------------------------------
// e2u_ctrl
// Controller: sequences the divider steps, the year and month loops and the
// hand-off of each finished word to the output register.
// ----------------------------------------------------------------------------
module e2u_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output e2u_pkg::cmd_t     cmd,
    input  e2u_pkg::status_t  status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DDAY  = 3'd1;
    localparam logic [2:0] ST_DHOUR = 3'd2;
    localparam logic [2:0] ST_DMIN  = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [e2u_pkg::STEP_W-1:0] PH_EST = 2'd0;
    localparam logic [e2u_pkg::STEP_W-1:0] PH_REM = 2'd1;
    localparam logic [e2u_pkg::STEP_W-1:0] PH_FIX = 2'd2;

    logic [2:0]                  state_reg, state_next;
    logic [e2u_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        out_free;
    logic [2:0]                  div_after;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.div_sel    = e2u_pkg::DIV_DAY;
        div_after      = ST_DHOUR;
        m_valid_next   = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = PH_EST;
                    state_next = ST_DDAY;
                end
            end
            ST_DDAY, ST_DHOUR, ST_DMIN: begin
                if (state_reg == ST_DHOUR) begin
                    cmd.div_sel = e2u_pkg::DIV_HOUR;
                    div_after   = ST_DMIN;
                end else if (state_reg == ST_DMIN) begin
                    cmd.div_sel = e2u_pkg::DIV_MIN;
                    div_after   = ST_YEAR;
                end
                unique case (step_reg)
                    PH_EST: begin
                        cmd.div_est = 1'b1;
                        step_next   = PH_REM;
                    end
                    PH_REM: begin
                        cmd.div_rem = 1'b1;
                        step_next   = PH_FIX;
                    end
                    default: begin
                        cmd.div_fix = 1'b1;
                        step_next   = PH_EST;
                        state_next  = div_after;
                    end
                endcase
            end
            ST_YEAR: begin
                if (status.year_done) begin
                    state_next = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (status.month_done) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= PH_EST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hdl/e2u_checker.sv
// ----------------------------------------------------------------------------
// e2u_checker
// Port-level checks for the epoch to UTC converter, bound to the top level.
// ----------------------------------------------------------------------------
module e2u_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_epoch_seconds,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_year,
    input logic [3:0]  m_month,
    input logic [4:0]  m_day,
    input logic [4:0]  m_hour,
    input logic [5:0]  m_minute,
    input logic [5:0]  m_second
);

    // A stalled result word holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_year) && $stable(m_month) &&
            $stable(m_day) && $stable(m_hour) && $stable(m_minute) && $stable(m_second))
        else $error("result word changed while stalled");

    // A stalled input word holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_epoch_seconds))
        else $error("input word changed while stalled");

    // The converter works on one word at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a conversion is running");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_year >= 12'd1970 && m_year <= 12'd2106 &&
            m_month >= 4'd1 && m_month <= 4'd12 && m_day >= 5'd1)
        else $error("date out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59)
        else $error("time of day out of range");

endmodule

bind epoch_to_utc_converter e2u_checker u_e2u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_epoch_seconds (s_epoch_seconds),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_year          (m_year),
    .m_month         (m_month),
    .m_day           (m_day),
    .m_hour          (m_hour),
    .m_minute        (m_minute),
    .m_second        (m_second)
);

// File: bench/tb_epoch_to_utc_converter.sv
// ----------------------------------------------------------------------------
// tb_epoch_to_utc_converter
// Self-checking bench for the epoch to UTC converter. A queue of epoch
// words is fed through a valid/ready driver. The bench predicts each
// calendar result from the accepted word, and a monitor compares every
// returned word field by field. Stimulus starts with calendar corner cases.
// It then moves on to random words, some uniform and some aimed at day, month
// and year boundaries from 1970 to 2106. Both handshakes stall at random, except
// in one window each where they never stall.
// ----------------------------------------------------------------------------
module tb_epoch_to_utc_converter;

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned RANDOM_WORDS = 1800;
    localparam int unsigned BURST_FIRST  = 900;
    localparam int unsigned BURST_LAST   = 1200;
    localparam int unsigned DAY_SECS     = 86400;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } utc_stamp_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [31:0] s_epoch_seconds = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;

    logic [31:0] pending_secs[$];
    utc_stamp_t  expected_stamps[$];
    int unsigned words_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned words_queued  = 0;
    int unsigned mismatches    = 0;
    int unsigned stall_cycles  = 0;

    epoch_to_utc_converter uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit gregorian_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned mi, bit leap);
        case (mi)
            1:             return leap ? 29 : 28;
            3, 5, 8, 10:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic utc_stamp_t to_utc(logic [31:0] secs);
        int unsigned days;
        int unsigned rem;
        int unsigned y;
        int unsigned mi;
        int unsigned len;
        utc_stamp_t  stamp;
        days = secs / DAY_SECS;
        rem = secs % DAY_SECS;
        stamp.hour = 5'(rem / 3600);
        rem = rem % 3600;
        stamp.minute = 6'(rem / 60);
        stamp.second = 6'(rem % 60);
        y = 1970;
        len = gregorian_leap(y) ? 366 : 365;
        while (days >= len) begin
            days -= len;
            y++;
            len = gregorian_leap(y) ? 366 : 365;
        end
        mi = 0;
        len = days_in_month(mi, gregorian_leap(y));
        while (mi < 11 && days >= len) begin
            days -= len;
            mi++;
            len = days_in_month(mi, gregorian_leap(y));
        end
        stamp.year = 12'(y);
        stamp.month = 4'(mi + 1);
        stamp.day = 5'(days + 1);
        return stamp;
    endfunction

    function automatic longint month_start_secs(int unsigned y, int unsigned m);
        longint      days;
        int unsigned i;
        days = 0;
        for (i = 1970; i < y; i++) begin
            days += gregorian_leap(i) ? 366 : 365;
        end
        for (i = 0; i < m; i++) begin
            days += days_in_month(i, gregorian_leap(y));
        end
        return days * DAY_SECS;
    endfunction

    task automatic queue_secs(longint secs);
        pending_secs.push_back(32'(secs));
        words_queued++;
    endtask

    task automatic compare_stamp(utc_stamp_t want);
        if (m_year !== want.year) begin
            $error("year: expected %0d, got %0d", want.year, m_year);
            mismatches++;
        end
        if (m_month !== want.month) begin
            $error("month: expected %0d, got %0d", want.month, m_month);
            mismatches++;
        end
        if (m_day !== want.day) begin
            $error("day: expected %0d, got %0d", want.day, m_day);
            mismatches++;
        end
        if (m_hour !== want.hour) begin
            $error("hour: expected %0d, got %0d", want.hour, m_hour);
            mismatches++;
        end
        if (m_minute !== want.minute) begin
            $error("minute: expected %0d, got %0d", want.minute, m_minute);
            mismatches++;
        end
        if (m_second !== want.second) begin
            $error("second: expected %0d, got %0d", want.second, m_second);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_stamps.push_back(to_utc(s_epoch_seconds));
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_secs.size() != 0 &&
                    ((words_sent >= BURST_FIRST && words_sent < BURST_LAST) ||
                     $urandom_range(0, 99) >= 26)) begin
                    s_valid <= 1'b1;
                    s_epoch_seconds <= pending_secs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stamps.size() == 0) begin
                    $error("result word with no expected word pending: %0d-%0d-%0d",
                           m_year, m_month, m_day);
                    mismatches++;
                end else begin
                    compare_stamp(expected_stamps.pop_front());
                end
                words_checked++;
            end
            m_ready <= (words_checked >= BURST_FIRST && words_checked < BURST_LAST) ||
                       ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned kind;
        int unsigned y;
        int unsigned m;
        longint      secs;
        longint      offset;

        // Time-of-day edges, leap days of 1972 and 2000, the missing leap
        // day of 2100, the signed 32-bit rollover and the top of the range.
        queue_secs(0);
        queue_secs(1);
        queue_secs(59);
        queue_secs(60);
        queue_secs(3599);
        queue_secs(3600);
        queue_secs(DAY_SECS - 1);
        queue_secs(DAY_SECS);
        queue_secs(month_start_secs(1972, 1) + 28 * DAY_SECS);
        queue_secs(month_start_secs(1972, 2));
        queue_secs(month_start_secs(1973, 0) - 1);
        queue_secs(month_start_secs(2000, 1) + 27 * DAY_SECS);
        queue_secs(month_start_secs(2000, 1) + 28 * DAY_SECS);
        queue_secs(month_start_secs(2000, 2));
        queue_secs(month_start_secs(2001, 0) - 1);
        queue_secs(month_start_secs(2100, 1) + 27 * DAY_SECS + DAY_SECS - 1);
        queue_secs(month_start_secs(2100, 2));
        queue_secs(month_start_secs(2101, 0) - 1);
        queue_secs(month_start_secs(2106, 0));
        queue_secs(32'h7FFF_FFFF);
        queue_secs(32'h8000_0000);
        queue_secs(32'hAAAA_AAAA);
        queue_secs(32'h5555_5555);
        queue_secs(32'hFFFF_FFFF);

        repeat (RANDOM_WORDS) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                secs = longint'($urandom());
            end else if (kind < 7) begin
                secs = longint'($urandom_range(0, 49709)) * DAY_SECS;
                secs += $urandom_range(0, 1) ? longint'($urandom_range(0, 3))
                                             : longint'(DAY_SECS - 1 - $urandom_range(0, 3));
            end else begin
                y = $urandom_range(1970, 2106);
                m = (kind == 7) ? 0 : $urandom_range(0, 11);
                offset = $urandom_range(0, 1) ? longint'($urandom_range(0, 7200))
                                              : -1 - longint'($urandom_range(0, 7200));
                secs = month_start_secs(y, m) + offset;
                if (secs < 0 || secs > 64'hFFFF_FFFF) begin
                    secs = longint'($urandom());
                end
            end
            queue_secs(secs);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_sent != words_queued || expected_stamps.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_stamps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
